// ===== rtl/ksc_pkg.sv =====
// shared types and constants for the keyword substitution cipher
package ksc_pkg;

  localparam int unsigned LETTERS = 26;

  typedef logic [4:0] idx_t;
  typedef logic [7:0] byte_t;

  localparam byte_t LETTER_A = 8'h41;
  localparam byte_t LETTER_Z = 8'h5A;
  localparam idx_t  LAST_IDX = 5'd25;
  localparam idx_t  CNT_FULL = 5'd26;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;
  localparam logic DIR_ENC   = 1'b0;
  localparam logic DIR_DEC   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take_kw;
    logic take_data;
    logic fill_start;
    logic fill_step;
    logic fill_finish;
  } ksc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic table_ready;
    logic scan_last;
    logic out_busy;
  } ksc_status_t;

endpackage

// ===== rtl/ksc_ctrl.sv =====
// controller: request acceptance and alphabet fill sequencing
module ksc_ctrl import ksc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_mode_i,
  input  ksc_status_t stat_i,
  output ksc_cmd_t    cmd_o,
  output logic        in_ready_o
);

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   take;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    take       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        // a data request waits until the alphabet is complete
        in_ready_o = ((in_mode_i == MODE_KEY) || stat_i.table_ready) && !stat_i.out_busy;
        take       = in_valid_i && in_ready_o;
        cmd_o.take_kw   = take && (in_mode_i == MODE_KEY);
        cmd_o.take_data = take && (in_mode_i == MODE_DATA);
        if (in_valid_i && (in_mode_i == MODE_DATA) && !stat_i.table_ready) begin
          cmd_o.fill_start = 1'b1;
          state_d          = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.scan_last) begin
          cmd_o.fill_finish = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/ksc_datapath.sv =====
// datapath: alphabet state, cipher and inverse tables, output register
module ksc_datapath import ksc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ksc_cmd_t    cmd_i,
  output ksc_status_t stat_o,
  input  byte_t       in_byte_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_data_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output byte_t       out_byte_o
);

  logic [LETTERS-1:0] used_q, used_d, base_used;
  idx_t               cnt_q, cnt_d, base_cnt;
  logic               ready_q, ready_d;
  idx_t               scan_q, scan_d;
  logic               dir_q;
  logic               out_valid_q;
  byte_t              out_q;

  idx_t cipher_q  [LETTERS];
  idx_t inverse_q [LETTERS];

  logic  is_upper;
  byte_t diff;
  idx_t  byte_idx;
  logic  app_en;
  idx_t  app_idx;
  logic  wr_en;
  idx_t  lookup;

  assign is_upper = (in_byte_i >= LETTER_A) && (in_byte_i <= LETTER_Z);
  assign diff     = in_byte_i - LETTER_A;
  assign byte_idx = diff[4:0];

  always_comb begin
    ready_d   = ready_q;
    scan_d    = scan_q;
    base_used = used_q;
    base_cnt  = cnt_q;
    app_en    = 1'b0;
    app_idx   = scan_q;
    // keyword after data drops the old alphabet
    if (cmd_i.take_kw && ready_q) begin
      base_used = '0;
      base_cnt  = '0;
      ready_d   = 1'b0;
    end
    if (cmd_i.take_kw && is_upper) begin
      app_en  = 1'b1;
      app_idx = byte_idx;
    end
    if (cmd_i.fill_start) begin
      scan_d = LAST_IDX;
    end
    if (cmd_i.fill_step) begin
      app_en  = 1'b1;
      app_idx = scan_q;
      scan_d  = scan_q - 5'd1;
    end
    if (cmd_i.fill_finish) begin
      ready_d = 1'b1;
    end
    wr_en  = app_en && (base_cnt < CNT_FULL) && !base_used[app_idx];
    used_d = base_used;
    cnt_d  = base_cnt;
    if (wr_en) begin
      used_d = base_used | (LETTERS'(1) << app_idx);
      cnt_d  = base_cnt + 5'd1;
    end
  end

  // inverse entry written together with the cipher entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cipher_q[base_cnt] <= app_idx;
      inverse_q[app_idx] <= base_cnt;
    end
  end

  assign lookup = (dir_q == DIR_DEC) ? inverse_q[byte_idx] : cipher_q[byte_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_data) begin
      out_q <= is_upper ? (LETTER_A + {3'b000, lookup}) : in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      scan_q      <= LAST_IDX;
      dir_q       <= DIR_ENC;
      out_valid_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      cnt_q   <= cnt_d;
      ready_q <= ready_d;
      scan_q  <= scan_d;
      if (cfg_valid_i) begin
        dir_q <= cfg_data_i;
      end
      if (cmd_i.take_data) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_q;
  assign stat_o.table_ready = ready_q;
  assign stat_o.scan_last   = (scan_q == '0);
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("keyword count beyond alphabet size");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> ((&used_q) && (cnt_q == CNT_FULL)))
    else $error("table marked ready with letters missing");

  a_data_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_data |-> ready_q)
    else $error("data request taken before table complete");

  a_fill_sets_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_finish |=> ready_q)
    else $error("fill finished without table ready");

endmodule

// ===== rtl/keyword_substitution_cipher.sv =====
// top level of the keyword substitution cipher
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: in_byte, tuser: mode
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: out_byte
// cfg       in   cfg_valid_i/cfg_ready_o          direction (0 encrypt, 1 decrypt)
//
// a keyword request gives no result
// a data request gives one result in the output register
// the first data request after a keyword waits while the scan is started and then
//   the alphabet is completed from Z down to A, one letter a cycle
// reset clears the alphabet state and the direction; tables need no clearing
// a result held in the output register stalls input only while m_axis_tready_i is low
module keyword_substitution_cipher import ksc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // keyword or data request
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] mode
  // result
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  // direction register
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  ksc_cmd_t    cmd;
  ksc_status_t stat;

  // direction register always writable
  assign cfg_ready_o = 1'b1;

  ksc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_mode_i  (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready_o)
  );

  ksc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_byte_i   (s_axis_tdata_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o)
  );

endmodule

// ===== verif/tb_keyword_substitution_cipher.sv =====
// testbench for the keyword substitution cipher with a cycle-free alphabet predictor
module tb_keyword_substitution_cipher;
  import ksc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // longest random gap or stall per request, in cycles
  localparam int unsigned MAX_IDLE = 11;
  // settle time after the last result: covers the alphabet scan
  localparam int unsigned SETTLE_CYCLES = 32;
  // length of the long receiver hold-off
  localparam int unsigned LONG_HOLD = 300;
  // random requests to send
  localparam int unsigned RANDOM_ITEMS = 500;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = '0;   // [7:0] in_byte
  logic       s_axis_tuser_i = 1'b0; // [0] mode
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;        // [7:0] out_byte
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;

  keyword_substitution_cipher dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted cipher state
  // ---------------------------------------------------------------------------
  logic [LETTERS-1:0] letters_taken;   // letters already placed in the alphabet
  int unsigned        alphabet_len;    // positions filled so far, 0..26
  bit                 alphabet_done;   // alphabet completed and inverse built
  idx_t               key_alphabet [LETTERS];
  idx_t               key_inverse  [LETTERS];
  logic               cipher_dir;      // DIR_ENC or DIR_DEC

  byte_t       expected_bytes [$];     // predicted out_byte values, oldest first
  int unsigned mismatch_count;
  int unsigned items_sent;

  // shared knobs for the stimulus processes
  bit          no_idle;                // both sides run without gaps
  int unsigned hold_req;               // receiver hold-off request, in cycles

  function automatic void clear_alphabet();
    letters_taken = '0;
    alphabet_len  = 0;
    alphabet_done = 1'b0;
  endfunction

  // place one letter at the next free position unless it is already there
  function automatic void place_letter(int unsigned idx);
    if (idx < LETTERS && alphabet_len < LETTERS && !letters_taken[idx]) begin
      letters_taken[idx]         = 1'b1;
      key_alphabet[alphabet_len] = idx_t'(idx);
      alphabet_len++;
    end
  endfunction

  // apply one accepted request to the predicted state, queue its result if any
  function automatic void cipher_request(logic mode, byte_t ch);
    bit    upper;
    byte_t out_ch;
    idx_t  pos;
    upper = (ch >= LETTER_A) && (ch <= LETTER_Z);
    if (mode == MODE_KEY) begin
      // any keyword request after data starts over
      if (alphabet_done) clear_alphabet();
      if (upper) place_letter(ch - LETTER_A);
    end else begin
      if (!alphabet_done) begin
        // remaining letters from Z down to A, then the inverse
        for (int k = LETTERS - 1; k >= 0; k--) place_letter(k);
        for (int k = 0; k < LETTERS; k++) key_inverse[key_alphabet[k]] = idx_t'(k);
        alphabet_done = 1'b1;
      end
      out_ch = ch;
      if (upper) begin
        pos = idx_t'(ch - LETTER_A);
        out_ch = LETTER_A + ((cipher_dir == DIR_DEC) ? key_inverse[pos] : key_alphabet[pos]);
      end
      expected_bytes.push_back(out_ch);
    end
  endfunction

  initial begin
    clear_alphabet();
    cipher_dir     = DIR_ENC;
    mismatch_count = 0;
    items_sent     = 0;
    no_idle        = 1'b0;
    hold_req       = 0;
  end

  // ---------------------------------------------------------------------------
  // monitors: predict on every accepted request, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      cipher_request(s_axis_tuser_i, s_axis_tdata_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte: result with no request pending, got %h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        if (m_axis_tdata_o !== expected_bytes[0]) begin
          $error("out_byte mismatch: expected %h, actual %h",
                 expected_bytes[0], m_axis_tdata_o);
          mismatch_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall before each result, long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      // also leave the wait when a hold-off is asked for
      do @(posedge clk_i); while (!m_axis_tvalid_o && hold_req == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers
  // ---------------------------------------------------------------------------

  // offer one request; tvalid stays high afterwards so back-to-back requests
  // follow without a gap, end_burst lowers it
  task automatic send_item(logic mode, byte_t ch);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // lower tvalid to end a burst
  task automatic end_burst();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every result, then let any keyword or scan work drain
  task automatic wait_idle();
    end_burst();
    do @(posedge clk_i); while (expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_direction(logic dir);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dir;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cipher_dir = dir;
  endtask

  task automatic send_text(logic mode, string text);
    for (int i = 0; i < text.len(); i++) send_item(mode, byte_t'(text[i]));
  endtask

  function automatic byte_t random_letter();
    return LETTER_A + byte_t'($urandom_range(0, LETTERS - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // data before any keyword: alphabet is Z down to A; byte range edges pass through
  task automatic test_no_keyword();
    send_text(MODE_DATA, "AZ");
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_text(MODE_DATA, "@[a");
    end_burst();
  endtask

  // repeated letters and bytes outside A-Z are ignored in the keyword,
  // a keyword after data drops the old alphabet
  task automatic test_keyword_rules();
    send_text(MODE_KEY, "KEY");
    send_item(MODE_KEY, 8'h00);
    send_item(MODE_KEY, 8'hFF);
    send_text(MODE_KEY, "eE@[WORD");
    send_text(MODE_DATA, "AMZz");
    end_burst();
  endtask

  // decrypt direction on the alphabet left by the previous test
  task automatic test_decrypt();
    write_direction(DIR_DEC);
    send_text(MODE_DATA, "KAZ");
    end_burst();
  endtask

  // one phase: keyword (sometimes none or noise), then data; mostly well-formed
  task automatic random_phase();
    int unsigned kind;
    int unsigned kw_len;
    int unsigned data_len;
    int unsigned j;
    idx_t        order [LETTERS];
    idx_t        tmp;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // full 26-letter keyword in random order, then some surplus letters
      for (int k = 0; k < LETTERS; k++) order[k] = idx_t'(k);
      for (int k = LETTERS - 1; k > 0; k--) begin
        j        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
      for (int k = 0; k < LETTERS; k++) send_item(MODE_KEY, LETTER_A + order[k]);
      repeat ($urandom_range(0, 3)) send_item(MODE_KEY, random_letter());
    end else if (kind == 9) begin
      // noise: random kinds and bytes
      repeat (8) send_item(logic'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)));
    end else if (kind != 1) begin
      kw_len = $urandom_range(1, 12);
      repeat (kw_len) begin
        if ($urandom_range(0, 5) == 0) send_item(MODE_KEY, byte_t'($urandom_range(0, 255)));
        else send_item(MODE_KEY, random_letter());
      end
    end
    data_len = $urandom_range(1, 16);
    repeat (data_len) begin
      if ($urandom_range(0, 2) != 0) send_item(MODE_DATA, random_letter());
      else send_item(MODE_DATA, byte_t'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random();
    int unsigned target;
    target = items_sent + RANDOM_ITEMS;
    write_direction(DIR_ENC);
    while (items_sent < target) begin
      // some phases run with no gaps on either side
      no_idle = ($urandom_range(0, 4) == 0);
      random_phase();
      if ($urandom_range(0, 3) == 0) write_direction(logic'($urandom_range(0, 1)));
    end
    no_idle = 1'b0;
    end_burst();
  endtask

  // receiver holds off while requests keep coming, so the input stalls;
  // afterwards the sender waits for every result
  task automatic test_backpressure();
    wait_idle();
    hold_req = LONG_HOLD;
    no_idle  = 1'b1;
    send_text(MODE_KEY, "CIPHER");
    repeat (30) send_item(MODE_DATA, random_letter());
    no_idle = 1'b0;
    wait_idle();
    send_text(MODE_DATA, "QZ");
    end_burst();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_keyword();
    test_keyword_rules();
    test_decrypt();
    test_random();
    test_backpressure();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ksc_pkg.sv
rtl/ksc_ctrl.sv
rtl/ksc_datapath.sv
rtl/keyword_substitution_cipher.sv
verif/tb_keyword_substitution_cipher.sv
